// ===== hdl/rf_remote_switch_frame_encoder_assert.svh =====
// Assertion macros for the frame encoder checker.
`ifndef RF_REMOTE_SWITCH_FRAME_ENCODER_ASSERT_SVH
`define RF_REMOTE_SWITCH_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define RFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rfe_pkg;

  localparam int SYSTEM_BITS = 5;
  localparam int UNIT_SLOTS  = 5;
  localparam int CODE_W      = SYSTEM_BITS + UNIT_SLOTS + 2;
  localparam int LEN_W       = $clog2(CODE_W + 1);
  localparam int CODE_EXT_W  = 2 ** LEN_W;

  localparam int SYS_W      = 5;
  localparam int UNIT_W     = 3;
  localparam int SW_W       = 2;
  localparam int SYS_EXT_W  = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam int DUR_W  = 16;
  localparam int REP_W  = 8;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [DUR_W-1:0] SHORT_RST    = 16'd375;
  localparam logic [DUR_W-1:0] LONG_RST     = 16'd1025;
  localparam logic [DUR_W-1:0] SYNC_GAP_RST = 16'd11625;
  localparam logic [REP_W-1:0] REPEAT_RST   = 8'd10;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_AW-1:0] {
    CFG_SHORT    = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_SYNC_GAP = 2'd2,
    CFG_REPEAT   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  typedef enum logic [SW_W-1:0] {
    SW_DOWN_UP   = 2'd0,
    SW_DOWN_DOWN = 2'd1,
    SW_NONE_2    = 2'd2,
    SW_NONE_3    = 2'd3
  } sw_code_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_len;
  } rfe_item_t;

  function automatic logic [DUR_W-1:0] at_least_one(input logic [DUR_W-1:0] v);
    return (v == '0) ? DUR_W'(1) : v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rf_remote_switch_frame_encoder.sv =====
// On-off keyed frame encoder for a 433 MHz remote power switch. A beat with
// in_tuser high starts a transmission of system code, one-hot unit and
// command bits (ignored while busy); each beat with in_tuser low is one time
// tick and returns the pin level for that tick. Every input beat yields exactly
// one output beat. The block sustains one beat per clock while the output is
// not stalled: the waveform engine updates its tick count, segment and bit
// index once per beat. An input beat is registered in the two-entry queue,
// then in the output register. Either side may stall; the queue decouples the
// classifier and engine, so input is taken while a result waits, until full.
`timescale 1ns / 1ps
`default_nettype none
module rf_remote_switch_frame_encoder
  import rfe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_AW-1:0]     cfg_addr,
  input  wire logic [CFG_DW-1:0]     cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [4:0] system_code, [7:5] unit_number, [9:8] switch_code, rest zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] command
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] pin_level, [1] busy_res, [2] done_res, [3] start_ignored, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic      q_full;
  logic      q_push;
  rfe_item_t q_push_item;
  logic      q_pop;
  rfe_item_t q_pop_item;
  logic      q_not_empty;

  rfe_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  rfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .not_empty (q_not_empty)
  );

  rfe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_item      (q_pop_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/rfe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfe_front
  import rfe_pkg::*;
(
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tuser,
  input  wire logic                 q_full,
  output logic                      q_push,
  output rfe_item_t                 q_item
);

  logic [SYS_W-1:0]     sys;
  logic [UNIT_W-1:0]    unit;
  sw_code_t             sw;
  logic [SYS_EXT_W-1:0] sys_ext;
  logic                 unit_ok;
  logic                 sw_ok;
  logic [CODE_W-1:0]    word;
  logic [LEN_W-1:0]     len;

  assign sys     = in_tdata[SYS_W-1:0];
  assign unit    = in_tdata[SYS_W+UNIT_W-1:SYS_W];
  assign sw      = sw_code_t'(in_tdata[SYS_W+UNIT_W+SW_W-1:SYS_W+UNIT_W]);
  assign sys_ext = SYS_EXT_W'(sys);
  assign unit_ok = (unit != '0) && ({1'b0, unit} <= 4'(UNIT_SLOTS));
  assign sw_ok   = (sw == SW_DOWN_UP) || (sw == SW_DOWN_DOWN);

  // system bits MSB first, one-hot unit slots, then two command bits
  always_comb begin
    word = '0;
    for (int i = 0; i < SYSTEM_BITS; i++) begin
      word[i] = sys_ext[SYSTEM_BITS-1-i];
    end
    for (int k = 0; k < UNIT_SLOTS; k++) begin
      word[SYSTEM_BITS+k] = unit_ok && ({1'b0, unit} == 4'(k + 1));
    end
    if (sw == SW_DOWN_UP) begin
      if (unit_ok) begin
        word[SYSTEM_BITS+UNIT_SLOTS+1] = 1'b1;
      end else begin
        word[SYSTEM_BITS+1] = 1'b1;
      end
    end
    len = LEN_W'(SYSTEM_BITS)
        + (unit_ok ? LEN_W'(UNIT_SLOTS) : LEN_W'(0))
        + (sw_ok ? LEN_W'(2) : LEN_W'(0));
  end

  assign in_tready        = !q_full;
  assign q_push           = in_tvalid && !q_full;
  assign q_item.cmd       = cmd_t'(in_tuser);
  assign q_item.code_word = word;
  assign q_item.code_len  = len;

endmodule
`default_nettype wire

// ===== hdl/rfe_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfe_fifo
  import rfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire rfe_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output rfe_item_t      pop_item,
  output logic           not_empty
);

  rfe_item_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rfe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfe_back
  import rfe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_AW-1:0]     cfg_addr,
  input  wire logic [CFG_DW-1:0]     cfg_wdata,
  input  wire logic                  q_not_empty,
  input  wire rfe_item_t             q_item,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic [DUR_W-1:0]  short_r, long_r, gap_r;
  logic [REP_W-1:0]  repeat_r;

  logic              busy_r, busy_nxt;
  logic [CODE_W-1:0] code_word_r, code_word_nxt;
  logic [LEN_W-1:0]  code_len_r, code_len_nxt;
  logic [LEN_W-1:0]  bit_pos_r, bit_pos_nxt;
  logic [1:0]        seg_r, seg_nxt;
  logic              in_sync_r, in_sync_nxt;
  logic [DUR_W-1:0]  ticks_r, ticks_nxt;
  logic [REP_W-1:0]  reps_r, reps_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [DUR_W-1:0]      s_len, l_len, g_len, t_dec;
  logic [CODE_EXT_W-1:0] code_ext;
  logic                  cur_bit;
  logic [LEN_W-1:0]      bit_pos_inc;
  logic [REP_W-1:0]      reps_dec;
  logic                  level, busy_o, done_o, ignored_o;
  logic                  end_frame;

  assign s_len       = at_least_one(short_r);
  assign l_len       = at_least_one(long_r);
  assign g_len       = at_least_one(gap_r);
  assign code_ext    = CODE_EXT_W'(code_word_r);
  assign cur_bit     = code_ext[bit_pos_r];
  assign bit_pos_inc = bit_pos_r + 1'b1;
  assign reps_dec    = reps_r - 1'b1;
  assign t_dec       = (ticks_r == '0) ? '0 : ticks_r - 1'b1;

  assign q_pop = q_not_empty && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r  <= SHORT_RST;
      long_r   <= LONG_RST;
      gap_r    <= SYNC_GAP_RST;
      repeat_r <= REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_SHORT:    short_r  <= cfg_wdata;
        CFG_LONG:     long_r   <= cfg_wdata;
        CFG_SYNC_GAP: gap_r    <= cfg_wdata;
        CFG_REPEAT:   repeat_r <= cfg_wdata[REP_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    code_word_nxt = code_word_r;
    code_len_nxt  = code_len_r;
    bit_pos_nxt   = bit_pos_r;
    seg_nxt       = seg_r;
    in_sync_nxt   = in_sync_r;
    ticks_nxt     = ticks_r;
    reps_nxt      = reps_r;
    level         = 1'b0;
    busy_o        = 1'b0;
    done_o        = 1'b0;
    ignored_o     = 1'b0;
    end_frame     = 1'b0;

    if (q_item.cmd == CMD_START) begin
      busy_o = 1'b1;
      if (busy_r) begin
        ignored_o = 1'b1;
        level     = !seg_r[0];
      end else begin
        code_word_nxt = q_item.code_word;
        code_len_nxt  = q_item.code_len;
        reps_nxt      = (repeat_r == '0) ? REP_W'(1) : repeat_r;
        busy_nxt      = 1'b1;
        in_sync_nxt   = 1'b1;
        seg_nxt       = '0;
        bit_pos_nxt   = '0;
        ticks_nxt     = s_len;
      end
    end else if (busy_r) begin
      busy_o    = 1'b1;
      level     = !seg_r[0];
      ticks_nxt = t_dec;
      if (t_dec == '0) begin
        if (in_sync_r) begin
          if (seg_r == 2'd0) begin
            seg_nxt   = 2'd1;
            ticks_nxt = g_len;
          end else begin
            in_sync_nxt = 1'b0;
            seg_nxt     = '0;
            bit_pos_nxt = '0;
            if (code_len_r == '0) begin
              end_frame = 1'b1;
            end else begin
              ticks_nxt = s_len;
            end
          end
        end else if (seg_r != 2'd3) begin
          seg_nxt = seg_r + 1'b1;
          case (seg_r)
            2'd0:    ticks_nxt = l_len;
            2'd1:    ticks_nxt = cur_bit ? s_len : l_len;
            default: ticks_nxt = cur_bit ? l_len : s_len;
          endcase
        end else begin
          bit_pos_nxt = bit_pos_inc;
          seg_nxt     = '0;
          if (bit_pos_inc < code_len_r) begin
            ticks_nxt = s_len;
          end else begin
            end_frame = 1'b1;
          end
        end
      end
      if (end_frame) begin
        reps_nxt    = reps_dec;
        seg_nxt     = '0;
        bit_pos_nxt = '0;
        if (reps_dec == '0) begin
          busy_nxt    = 1'b0;
          in_sync_nxt = 1'b0;
          ticks_nxt   = '0;
          done_o      = 1'b1;
        end else begin
          in_sync_nxt = 1'b1;
          ticks_nxt   = s_len;
        end
      end
    end

    out_data_nxt = OUT_DATA_W'({ignored_o, done_o, busy_o, level});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      code_word_r <= '0;
      code_len_r  <= '0;
      bit_pos_r   <= '0;
      seg_r       <= '0;
      in_sync_r   <= 1'b0;
      ticks_r     <= '0;
      reps_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r      <= busy_nxt;
        code_word_r <= code_word_nxt;
        code_len_r  <= code_len_nxt;
        bit_pos_r   <= bit_pos_nxt;
        seg_r       <= seg_nxt;
        in_sync_r   <= in_sync_nxt;
        ticks_r     <= ticks_nxt;
        reps_r      <= reps_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/rfe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "rf_remote_switch_frame_encoder_assert.svh"
module rfe_checker
  import rfe_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  `RFE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output beat changed while stalled")
  `RFE_ASSERT_NOW(a_done_busy, out_tvalid && out_tdata[2], out_tdata[1], "done reported without busy")
  `RFE_ASSERT_NOW(a_ignored, out_tvalid && out_tdata[3], out_tdata[1] && !out_tdata[2], "ignored start must be busy and not done")
  `RFE_ASSERT_NOW(a_idle_low, out_tvalid && !out_tdata[1], !out_tdata[0] && !out_tdata[3], "idle beat drives pin or ignore flag")

endmodule

bind rf_remote_switch_frame_encoder rfe_checker u_rfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
